FILE: sv/fmp_pkg.sv
package fmp_pkg;

    localparam int INDEX_BITS_DEF   = 47;
    localparam int MODULUS_BITS_DEF = 10;

    localparam int RESIDUE_W = 10;
    localparam int PERIOD_W  = 13;
    localparam int RIDX_W    = 13;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_PSTEP     = 4'd2,
        OP_DIV_INIT  = 4'd3,
        OP_DIV_STEP  = 4'd4,
        OP_WALK_INIT = 4'd5,
        OP_WALK_STEP = 4'd6,
        OP_EMIT      = 4'd7,
        OP_SMALL     = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_NO_INPUT  = 3'd1,
        COND_SMALL_MOD = 3'd2,
        COND_NOT_PAIR  = 3'd3,
        COND_DIV_MORE  = 3'd4,
        COND_REM_ZERO  = 3'd5,
        COND_WALK_MORE = 3'd6,
        COND_OUT_BUSY  = 3'd7
    } cond_t;

    localparam int PC_W     = 4;
    localparam int PROG_LEN = 10;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_WAIT      = 4'd0;
    localparam pc_t PC_CHECK     = 4'd1;
    localparam pc_t PC_PERIOD    = 4'd2;
    localparam pc_t PC_DIV_INIT  = 4'd3;
    localparam pc_t PC_DIV       = 4'd4;
    localparam pc_t PC_WALK_INIT = 4'd5;
    localparam pc_t PC_WALK      = 4'd6;
    localparam pc_t PC_EMIT      = 4'd7;
    localparam pc_t PC_RETURN    = 4'd8;
    localparam pc_t PC_SMALL     = 4'd9;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic small_mod;
        logic pair_next;
        logic div_more;
        logic rem_zero;
        logic walk_more;
        logic out_busy;
    } status_t;

    // jump to target when cond holds, else fall through
    function automatic uword_t ucode_rom(pc_t addr);
        uword_t w;
        w = '{op: OP_NONE, cond: COND_ALWAYS, target: PC_WAIT};
        case (addr)
            PC_WAIT:      w = '{op: OP_LOAD,      cond: COND_NO_INPUT,  target: PC_WAIT};
            PC_CHECK:     w = '{op: OP_NONE,      cond: COND_SMALL_MOD, target: PC_SMALL};
            PC_PERIOD:    w = '{op: OP_PSTEP,     cond: COND_NOT_PAIR,  target: PC_PERIOD};
            PC_DIV_INIT:  w = '{op: OP_DIV_INIT,  cond: COND_ALWAYS,    target: PC_DIV};
            PC_DIV:       w = '{op: OP_DIV_STEP,  cond: COND_DIV_MORE,  target: PC_DIV};
            PC_WALK_INIT: w = '{op: OP_WALK_INIT, cond: COND_REM_ZERO,  target: PC_EMIT};
            PC_WALK:      w = '{op: OP_WALK_STEP, cond: COND_WALK_MORE, target: PC_WALK};
            PC_EMIT:      w = '{op: OP_EMIT,      cond: COND_OUT_BUSY,  target: PC_EMIT};
            PC_RETURN:    w = '{op: OP_NONE,      cond: COND_ALWAYS,    target: PC_WAIT};
            PC_SMALL:     w = '{op: OP_SMALL,     cond: COND_ALWAYS,    target: PC_EMIT};
            default:      w = '{op: OP_NONE,      cond: COND_ALWAYS,    target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: sv/fmp_if.sv
interface fmp_req_if #(
    parameter int INDEX_BITS   = fmp_pkg::INDEX_BITS_DEF,
    parameter int MODULUS_BITS = fmp_pkg::MODULUS_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [INDEX_BITS-1:0]   n_index;
    logic [MODULUS_BITS-1:0] modulus;

    modport source (output valid, output n_index, output modulus, input ready);
    modport sink   (input valid, input n_index, input modulus, output ready);
endinterface

interface fmp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fmp_pkg::RESIDUE_W-1:0] fib_residue;
    logic [fmp_pkg::PERIOD_W-1:0]  pisano_period;
    logic [fmp_pkg::RIDX_W-1:0]    reduced_index;

    modport source (output valid, output fib_residue, output pisano_period,
                    output reduced_index, input ready);
    modport sink   (input valid, input fib_residue, input pisano_period,
                    input reduced_index, output ready);
endinterface

FILE: sv/fmp_sequencer.sv
module fmp_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  fmp_pkg::status_t  status,
    output fmp_pkg::uword_t   uword
);

    fmp_pkg::pc_t pc_reg;
    fmp_pkg::pc_t pc_next;
    logic         jump;

    assign uword = fmp_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        unique case (uword.cond)
            fmp_pkg::COND_ALWAYS:    jump = 1'b1;
            fmp_pkg::COND_NO_INPUT:  jump = !status.in_valid;
            fmp_pkg::COND_SMALL_MOD: jump = status.small_mod;
            fmp_pkg::COND_NOT_PAIR:  jump = !status.pair_next;
            fmp_pkg::COND_DIV_MORE:  jump = status.div_more;
            fmp_pkg::COND_REM_ZERO:  jump = status.rem_zero;
            fmp_pkg::COND_WALK_MORE: jump = status.walk_more;
            fmp_pkg::COND_OUT_BUSY:  jump = status.out_busy;
            default:                 jump = 1'b1;
        endcase
        pc_next = jump ? uword.target : pc_reg + fmp_pkg::pc_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= fmp_pkg::PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg < fmp_pkg::pc_t'(fmp_pkg::PROG_LEN))
        else $error("step counter left the program");

endmodule

FILE: sv/fmp_datapath.sv
module fmp_datapath #(
    parameter int INDEX_BITS   = fmp_pkg::INDEX_BITS_DEF,
    parameter int MODULUS_BITS = fmp_pkg::MODULUS_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fmp_pkg::uword_t   uword,
    output fmp_pkg::status_t  status,
    fmp_req_if.sink           req,
    fmp_rsp_if.source         rsp
);

    localparam int PW = MODULUS_BITS + 3;
    localparam int CW = $clog2(INDEX_BITS + 1);
    localparam int RW = fmp_pkg::RESIDUE_W;
    localparam int TW = fmp_pkg::PERIOD_W;
    localparam int KW = fmp_pkg::RIDX_W;

    logic [INDEX_BITS-1:0]   n_reg;
    logic [MODULUS_BITS-1:0] m_reg;
    logic [MODULUS_BITS-1:0] a_reg;
    logic [MODULUS_BITS-1:0] b_reg;
    logic [PW-1:0]           p_reg;
    logic [PW-1:0]           rem_reg;
    logic [PW-1:0]           walk_reg;
    logic [CW-1:0]           cnt_reg;
    logic [RW-1:0]           res_reg;
    logic [TW-1:0]           per_reg;
    logic [KW-1:0]           ridx_reg;
    logic                    out_valid_reg;

    logic [MODULUS_BITS:0]    sum;
    logic [MODULUS_BITS:0]    sum_red;
    logic [MODULUS_BITS-1:0]  t_mod;
    logic [PW:0]              shifted;
    logic [PW:0]              shifted_red;
    logic [PW-1:0]            rem_next;
    logic                     accept;
    logic                     emit;
    logic [MODULUS_BITS+RW-1:0] a_ext;
    logic [PW+TW-1:0]         p_ext;
    logic [PW+KW-1:0]         k_ext;

    assign sum     = {1'b0, a_reg} + {1'b0, b_reg};
    assign sum_red = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
    assign t_mod   = sum_red[MODULUS_BITS-1:0];

    assign shifted     = {rem_reg, n_reg[INDEX_BITS-1]};
    assign shifted_red = (shifted >= {1'b0, p_reg}) ? shifted - {1'b0, p_reg} : shifted;
    assign rem_next    = shifted_red[PW-1:0];

    assign req.ready = (uword.op == fmp_pkg::OP_LOAD);
    assign accept    = req.valid && req.ready;

    assign status.in_valid  = req.valid;
    assign status.small_mod = (m_reg < MODULUS_BITS'(2));
    assign status.pair_next = (b_reg == '0) && (t_mod == MODULUS_BITS'(1));
    assign status.div_more  = (cnt_reg != CW'(1));
    assign status.rem_zero  = (rem_reg == '0);
    assign status.walk_more = (walk_reg != PW'(1));
    assign status.out_busy  = out_valid_reg && !rsp.ready;

    assign emit = (uword.op == fmp_pkg::OP_EMIT) && !status.out_busy;

    assign a_ext = {{RW{1'b0}}, a_reg};
    assign p_ext = {{TW{1'b0}}, p_reg};
    assign k_ext = {{KW{1'b0}}, rem_reg};

    always_ff @(posedge clk)
    begin
        unique case (uword.op)
            fmp_pkg::OP_LOAD:
            begin
                if (accept)
                begin
                    n_reg <= req.n_index;
                    m_reg <= req.modulus;
                    a_reg <= '0;
                    b_reg <= MODULUS_BITS'(1);
                    p_reg <= '0;
                end
            end
            fmp_pkg::OP_PSTEP:
            begin
                a_reg <= b_reg;
                b_reg <= t_mod;
                p_reg <= p_reg + PW'(1);
            end
            fmp_pkg::OP_DIV_INIT:
            begin
                cnt_reg <= CW'(INDEX_BITS);
                rem_reg <= '0;
            end
            fmp_pkg::OP_DIV_STEP:
            begin
                rem_reg <= rem_next;
                n_reg   <= n_reg << 1;
                cnt_reg <= cnt_reg - CW'(1);
            end
            fmp_pkg::OP_WALK_INIT:
            begin
                a_reg    <= '0;
                b_reg    <= MODULUS_BITS'(1);
                walk_reg <= rem_reg;
            end
            fmp_pkg::OP_WALK_STEP:
            begin
                a_reg    <= b_reg;
                b_reg    <= t_mod;
                walk_reg <= walk_reg - PW'(1);
            end
            fmp_pkg::OP_SMALL:
            begin
                a_reg   <= '0;
                p_reg   <= PW'(1);
                rem_reg <= '0;
            end
            fmp_pkg::OP_EMIT:
            begin
                if (emit)
                begin
                    res_reg  <= a_ext[RW-1:0];
                    per_reg  <= p_ext[TW-1:0];
                    ridx_reg <= k_ext[KW-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.fib_residue   = res_reg;
    assign rsp.pisano_period = per_reg;
    assign rsp.reduced_index = ridx_reg;

    a_residues_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (uword.op == fmp_pkg::OP_PSTEP || uword.op == fmp_pkg::OP_WALK_STEP)
        |-> (a_reg < m_reg) && (b_reg < m_reg))
        else $error("residue pair not below modulus");

    a_period_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (uword.op == fmp_pkg::OP_PSTEP)
        |-> (p_reg < PW'(6) * {3'b000, m_reg}))
        else $error("period search ran past six times the modulus");

    a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(uword.op == fmp_pkg::OP_DIV_STEP) |-> (rem_reg < p_reg))
        else $error("partial remainder not below period");

endmodule

FILE: sv/fibonacci_mod_pisano_top.sv
// channel  dir  handshake      fields
// req      in   valid / ready  n_index[INDEX_BITS], modulus[MODULUS_BITS]
// rsp      out  valid / ready  fib_residue[10], pisano_period[13], reduced_index[13]
//
// One word in flight; the period search loop and the final walk both run on
// the one mod-m adder, and the reduction is a bit-serial divider, one index
// bit per cycle. A modulus below two takes a short path past the search and
// the divider. Reset clears the step counter and the output valid. A stalled
// rsp holds the result; req is taken again once the result register has been
// loaded.
module fibonacci_mod_pisano_top #(
    parameter int INDEX_BITS   = fmp_pkg::INDEX_BITS_DEF,
    parameter int MODULUS_BITS = fmp_pkg::MODULUS_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    fmp_req_if.sink    req,
    fmp_rsp_if.source  rsp
);

    fmp_pkg::uword_t  uword;
    fmp_pkg::status_t status;

    fmp_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uword  (uword)
    );

    fmp_datapath #(
        .INDEX_BITS   (INDEX_BITS),
        .MODULUS_BITS (MODULUS_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .uword  (uword),
        .status (status),
        .req    (req),
        .rsp    (rsp)
    );

endmodule
